// ===== rtl/core/rav_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotor angle and velocity tracker: shared package
// Field widths, register indexes, reset values and the controller states.
// ----------------------------------------------------------------------------
package rav_pkg;

   // Payload field widths
   localparam int SAMPLE_ANGLE_W = 14;
   localparam int TIMESTAMP_W    = 32;
   localparam int TURN_COUNT_W   = 32;
   localparam int TOTAL_ANGLE_W  = 46;
   localparam int SPEED_W        = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MIN_ELAPSED_W = 16;
   localparam int WRAP_THR_W    = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ELAPSED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_THR    = 2'd1;

   localparam logic [MIN_ELAPSED_W-1:0] MIN_ELAPSED_RST = 16'd100;
   localparam logic [WRAP_THR_W-1:0]    WRAP_THR_RST    = 14'd13107;

   // Default counts per revolution exponent
   localparam int DEF_ANGLE_BITS = 14;

   // Counts per second scale: microseconds per second
   localparam int SCALE_W = 20;
   localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd1000000;

   // Quotient bits below the saturation limit
   localparam int QUO_W = 31;
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] MUL_LAST = 5'(SCALE_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = 5'(QUO_W - 1);

   localparam logic [SPEED_W-1:0] SPEED_POS_SAT = 32'h7FFF_FFFF;
   localparam logic [SPEED_W-1:0] SPEED_NEG_SAT = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DELTA,
      ST_MAG,
      ST_MUL,
      ST_OVF,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } rav_state_type;

endpackage

// ===== rtl/core/rav_req_if.sv =====
// ----------------------------------------------------------------------------
// Sensor sample request channel
// Valid/ready channel carrying one angle sample with its timestamp.
// ----------------------------------------------------------------------------
interface rav_req_if;
   import rav_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SAMPLE_ANGLE_W-1:0] sample_angle;
   logic                      sample_error;
   logic [TIMESTAMP_W-1:0]    timestamp_us;

   modport source (output valid, output sample_angle, output sample_error,
                   output timestamp_us, input ready);
   modport sink   (input valid, input sample_angle, input sample_error,
                   input timestamp_us, output ready);
endinterface

// ===== rtl/core/rav_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Tracker result channel
// Valid/ready channel carrying multi-turn position and velocity.
// ----------------------------------------------------------------------------
interface rav_rsp_if;
   import rav_pkg::*;

   logic                            valid;
   logic                            ready;
   logic signed [TURN_COUNT_W-1:0]  turn_count;
   logic [SAMPLE_ANGLE_W-1:0]       shaft_angle;
   logic signed [TOTAL_ANGLE_W-1:0] total_angle;
   logic signed [SPEED_W-1:0]       speed;
   logic                            speed_updated;

   modport source (output valid, output turn_count, output shaft_angle,
                   output total_angle, output speed, output speed_updated,
                   input ready);
   modport sink   (input valid, input turn_count, input shaft_angle,
                   input total_angle, input speed, input speed_updated,
                   output ready);
endinterface

// ===== rtl/core/rav_csr_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rav_csr_if;
   import rav_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rotor_angle_velocity_tracker.sv =====
// ----------------------------------------------------------------------------
// Rotor angle and velocity tracker
// Multi-turn position tracking and counts-per-second velocity estimation.
// ----------------------------------------------------------------------------
// One request is processed at a time. An error sample goes from acceptance
// straight to the done state. A sample with a negative or short interval passes
// the check state, and one with no motion passes the check, delta and magnitude
// states. A sample that updates the velocity goes on through the serial path:
// shift-add steps that scale the angle change by one million, one bit of the
// constant per cycle, then restoring-division steps, one quotient bit per cycle,
// which are skipped when the speed saturates. The next request is
// accepted in the cycle after the result is loaded into the output register,
// so a waiting result does not hold off the next request.
// ----------------------------------------------------------------------------
module rotor_angle_velocity_tracker #(
   parameter int ANGLE_BITS = rav_pkg::DEF_ANGLE_BITS
) (
   input  logic          clock,
   input  logic          reset,
   rav_req_if.sink       req_ch,
   rav_rsp_if.source     rsp_ch,
   rav_csr_if.sink       csr_ch
);
   import rav_pkg::*;

   localparam int DELTA_W = ANGLE_BITS + 34;
   localparam int PROD_W  = DELTA_W + SCALE_W;
   localparam int HI_W    = PROD_W - QUO_W;
   localparam logic [SAMPLE_ANGLE_W-1:0] AngleMask = (ANGLE_BITS >= SAMPLE_ANGLE_W) ?
      {SAMPLE_ANGLE_W{1'b1}} : SAMPLE_ANGLE_W'((1 << ANGLE_BITS) - 1);

   rav_state_type state_ff, state_in;

   // Configuration
   logic [MIN_ELAPSED_W-1:0]  min_elapsed_ff;
   logic [WRAP_THR_W-1:0]     wrap_thr_ff;

   // Tracking state
   logic [SAMPLE_ANGLE_W-1:0] last_angle_ff, ref_angle_ff;
   logic [TURN_COUNT_W-1:0]   rot_ff, ref_rot_ff;
   logic [TIMESTAMP_W-1:0]    last_time_ff, ref_time_ff;
   logic [SPEED_W-1:0]        vel_ff;

   // Working registers
   logic [TIMESTAMP_W-1:0]    el_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic [DELTA_W-1:0]        mag_ff;
   logic                      neg_ff;
   logic                      sat_ff;
   logic                      upd_ff;
   logic [PROD_W-1:0]         acc_ff;
   logic [SCALE_W-1:0]        k_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [QUO_W-1:0]          rem_ff;
   logic [QUO_W-1:0]          quo_ff;

   // Output register
   logic                      rsp_valid_ff;
   logic [TURN_COUNT_W-1:0]   rsp_turn_ff;
   logic [SAMPLE_ANGLE_W-1:0] rsp_angle_ff;
   logic [TOTAL_ANGLE_W-1:0]  rsp_total_ff;
   logic [SPEED_W-1:0]        rsp_speed_ff;
   logic                      rsp_upd_ff;

   logic                      req_fire;
   logic                      rsp_load;
   logic [SAMPLE_ANGLE_W-1:0] angle_in;
   logic signed [SAMPLE_ANGLE_W:0] step_in;
   logic [SAMPLE_ANGLE_W:0]   step_mag;
   logic                      wrap_in;
   logic [TIMESTAMP_W-1:0]    el_in;
   logic signed [TURN_COUNT_W:0]   drot;
   logic signed [SAMPLE_ANGLE_W:0] adiff;
   logic signed [DELTA_W-1:0] delta_in;
   logic [QUO_W-1:0]          divisor;
   logic [HI_W-1:0]           acc_hi;
   logic [QUO_W:0]            rem_try;
   logic                      rem_ge;
   logic [QUO_W:0]            rem_sub;
   logic [TOTAL_ANGLE_W-1:0]  total_in;
   logic                      el_ok;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Wrap detection on the incoming sample
   assign angle_in = req_ch.sample_angle & AngleMask;
   assign step_in  = $signed({1'b0, angle_in}) - $signed({1'b0, last_angle_ff});
   assign step_mag = step_in[SAMPLE_ANGLE_W] ? 15'(-step_in) : 15'(step_in);
   assign wrap_in  = step_mag > {1'b0, wrap_thr_ff};
   assign el_in    = req_ch.timestamp_us - ref_time_ff;
   assign el_ok    = (el_ff >= {16'd0, min_elapsed_ff}) && (el_ff != '0);

   // Multi-turn change since the reference
   assign drot     = $signed({rot_ff[TURN_COUNT_W-1], rot_ff})
                   - $signed({ref_rot_ff[TURN_COUNT_W-1], ref_rot_ff});
   assign adiff    = $signed({1'b0, last_angle_ff}) - $signed({1'b0, ref_angle_ff});
   assign delta_in = (DELTA_W'(drot) <<< ANGLE_BITS) + DELTA_W'(adiff);

   // Divider datapath: one restoring step per cycle
   assign divisor  = el_ff[QUO_W-1:0];
   assign acc_hi   = acc_ff[PROD_W-1:QUO_W];
   assign rem_try  = {rem_ff, quo_ff[QUO_W-1]};
   assign rem_ge   = rem_try >= {1'b0, divisor};
   assign rem_sub  = rem_try - {1'b0, divisor};

   assign total_in = (TOTAL_ANGLE_W'(rot_ff) << ANGLE_BITS) + TOTAL_ANGLE_W'(last_angle_ff);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Hold the controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence the work of one request
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = req_ch.sample_error ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (el_ff[TIMESTAMP_W-1] || !el_ok) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: state_in = ST_MAG;
         ST_MAG: begin
            state_in = (delta_ff == '0) ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = ST_OVF;
            end
         end
         ST_OVF: begin
            state_in = (acc_hi >= HI_W'(divisor)) ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_elapsed_ff <= MIN_ELAPSED_RST;
         wrap_thr_ff    <= WRAP_THR_RST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_MIN_ELAPSED: min_elapsed_ff <= csr_ch.data[MIN_ELAPSED_W-1:0];
            CSR_WRAP_THR:    wrap_thr_ff    <= csr_ch.data[WRAP_THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Update tracking state, reference and velocity
   always_ff @(posedge clock) begin
      if (reset) begin
         last_angle_ff <= '0;
         rot_ff        <= '0;
         last_time_ff  <= '0;
         ref_angle_ff  <= '0;
         ref_rot_ff    <= '0;
         ref_time_ff   <= '0;
         vel_ff        <= '0;
         upd_ff        <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               upd_ff <= 1'b0;
               if (req_fire && !req_ch.sample_error) begin
                  last_angle_ff <= angle_in;
                  last_time_ff  <= req_ch.timestamp_us;
                  if (wrap_in) begin
                     rot_ff <= step_in[SAMPLE_ANGLE_W] ? rot_ff + 32'd1 : rot_ff - 32'd1;
                  end
               end
            end
            ST_CHECK: begin
               if (el_ff[TIMESTAMP_W-1]) begin
                  ref_angle_ff <= last_angle_ff;
                  ref_rot_ff   <= rot_ff;
                  ref_time_ff  <= last_time_ff;
               end
            end
            ST_FIN: begin
               if (sat_ff) begin
                  vel_ff <= neg_ff ? SPEED_NEG_SAT : SPEED_POS_SAT;
               end else begin
                  vel_ff <= neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
               end
               ref_angle_ff <= last_angle_ff;
               ref_rot_ff   <= rot_ff;
               ref_time_ff  <= last_time_ff;
               upd_ff       <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Working datapath: elapsed time, change, scale and divide
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            el_ff <= el_in;
         end
         ST_DELTA: begin
            delta_ff <= delta_in;
         end
         ST_MAG: begin
            neg_ff <= delta_ff[DELTA_W-1];
            mag_ff <= delta_ff[DELTA_W-1] ? DELTA_W'(-delta_ff) : DELTA_W'(delta_ff);
            acc_ff <= '0;
            k_ff   <= SPEED_SCALE;
            cnt_ff <= MUL_LAST;
         end
         ST_MUL: begin
            acc_ff <= (acc_ff << 1) + (k_ff[SCALE_W-1] ? PROD_W'(mag_ff) : '0);
            k_ff   <= k_ff << 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         ST_OVF: begin
            sat_ff <= acc_hi >= HI_W'(divisor);
            rem_ff <= acc_hi[QUO_W-1:0];
            quo_ff <= acc_ff[QUO_W-1:0];
            cnt_ff <= DIV_LAST;
         end
         ST_DIV: begin
            rem_ff <= rem_ge ? rem_sub[QUO_W-1:0] : rem_try[QUO_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], rem_ge};
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   // Output register: load when free or being drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_turn_ff  <= rot_ff;
         rsp_angle_ff <= last_angle_ff;
         rsp_total_ff <= total_in;
         rsp_speed_ff <= vel_ff;
         rsp_upd_ff   <= upd_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.turn_count    = $signed(rsp_turn_ff);
   assign rsp_ch.shaft_angle   = rsp_angle_ff;
   assign rsp_ch.total_angle   = $signed(rsp_total_ff);
   assign rsp_ch.speed         = $signed(rsp_speed_ff);
   assign rsp_ch.speed_updated = rsp_upd_ff;

   // Error samples leave the tracked angle alone
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.sample_error) |=> (last_angle_ff == $past(last_angle_ff)))
      else $error("error sample changed the tracked angle");

   // Partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < divisor))
      else $error("divider remainder out of range");

   // A velocity update moves the reference to the current sample
   a_ref_moved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> (ref_time_ff == last_time_ff && upd_ff))
      else $error("reference not taken after velocity update");

   // A result is loaded only from the done state and only when the slot frees
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready && state_ff == ST_DONE) |=> (state_ff == ST_DONE))
      else $error("result dropped while output register was full");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Rotor angle and velocity tracker: testbench
// Drives angle samples, configuration writes and result backpressure, runs a
// directed stimulus table and then random motion profiles, and checks each
// result field against a cycle-free tracker model kept in the testbench.
// ----------------------------------------------------------------------------
module testbench;
   import rav_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int          ANGLE_W         = DEF_ANGLE_BITS;
   localparam logic [79:0] US_PER_SECOND   = 80'd1000000;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          END_SETTLE      = 100;
   localparam int          RANDOM_PHASES   = 10;
   localparam int          SAMPLES_A_PHASE = 100;

   typedef struct packed {
      logic signed [TURN_COUNT_W-1:0]  turn_count;
      logic [SAMPLE_ANGLE_W-1:0]       shaft_angle;
      logic signed [TOTAL_ANGLE_W-1:0] total_angle;
      logic signed [SPEED_W-1:0]       speed;
      logic                            speed_updated;
   } track_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [CSR_IDX_W-1:0]           reg_index;
      logic [CSR_DATA_W-1:0]          reg_data;
      logic [SAMPLE_ANGLE_W-1:0]      angle;
      logic                           err;
      logic [TIMESTAMP_W-1:0]         ts;
      logic                           typed;
      logic signed [TURN_COUNT_W-1:0] want_turns;
      logic [SAMPLE_ANGLE_W-1:0]      want_shaft;
      logic signed [SPEED_W-1:0]      want_speed;
      logic                           want_updated;
   } stim_row_type;

   localparam int DIR_ROWS = 23;

   // Directed stimulus; expected values typed in only where obvious
   stim_row_type directed_rows [0:DIR_ROWS-1] = '{
      // after reset: no time has passed, nothing moves
      '{ROW_SAMPLE, '0, '0, 14'd0,     1'b0, 32'h0000_0000, 1'b1, 32'sd0, 14'd0, 32'sd0, 1'b0},
      // sensor error with every field at its top: state untouched
      '{ROW_SAMPLE, '0, '0, 14'd16383, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'sd0, 14'd0, 32'sd0, 1'b0},
      // interval below the minimum keeps the speed
      '{ROW_SAMPLE, '0, '0, 14'd1000,  1'b0, 32'h0000_0032, 1'b1, 32'sd0, 14'd1000,
        32'sd0, 1'b0},
      // 2000 counts in 1000 us
      '{ROW_SAMPLE, '0, '0, 14'd2000,  1'b0, 32'h0000_03E8, 1'b1, 32'sd0, 14'd2000,
        32'sd2000000, 1'b1},
      // no motion keeps speed and reference
      '{ROW_SAMPLE, '0, '0, 14'd2000,  1'b0, 32'h0000_07D0, 1'b1, 32'sd0, 14'd2000,
        32'sd2000000, 1'b0},
      // backward wrap, then forward wrap
      '{ROW_SAMPLE, '0, '0, 14'd16383, 1'b0, 32'h0000_0BB8, 1'b0, '0, '0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 14'd0,     1'b0, 32'h0000_0FA0, 1'b0, '0, '0, '0, '0},
      // elapsed reads negative: resync the reference
      '{ROW_SAMPLE, '0, '0, 14'd5000,  1'b0, 32'h9000_0000, 1'b0, '0, '0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 14'd5100,  1'b0, 32'h9000_0010, 1'b0, '0, '0, '0, '0},
      // long positive interval, then across the timestamp wrap
      '{ROW_SAMPLE, '0, '0, 14'd5200,  1'b0, 32'hFFFF_FFF0, 1'b0, '0, '0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 14'd5300,  1'b0, 32'h0000_0100, 1'b0, '0, '0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 14'd9000,  1'b0, 32'h0000_0050, 1'b0, '0, '0, '0, '0},
      // no minimum interval, every nonzero step wraps
      '{ROW_REG, CSR_MIN_ELAPSED, 16'h0000, '0, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_WRAP_THR,    16'h0000, '0, '0, '0, '0, '0, '0, '0, '0},
      // zero elapsed time with motion
      '{ROW_SAMPLE, '0, '0, 14'd9001,  1'b0, 32'h0000_0050, 1'b0, '0, '0, '0, '0},
      // net zero motion after two wraps, then nearly a turn back in two microseconds: negative saturation
      '{ROW_SAMPLE, '0, '0, 14'd9000,  1'b0, 32'h0000_0051, 1'b0, '0, '0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 14'd9001,  1'b0, 32'h0000_0052, 1'b0, '0, '0, '0, '0},
      // top threshold (upper data bits dropped), longest minimum, unused index
      '{ROW_REG, CSR_WRAP_THR,    16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_MIN_ELAPSED, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_REG, CSR_UNUSED,      16'h1234, '0, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 14'd0,     1'b0, 32'h0000_0053, 1'b0, '0, '0, '0, '0},
      // full-scale steps at the threshold count no wrap
      '{ROW_SAMPLE, '0, '0, 14'd16383, 1'b0, 32'h0001_0051, 1'b0, '0, '0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 14'd0,     1'b0, 32'h0002_0050, 1'b0, '0, '0, '0, '0}
   };

   logic clock;
   logic reset;

   rav_req_if req_bus ();
   rav_rsp_if rsp_bus ();
   rav_csr_if csr_bus ();

   rotor_angle_velocity_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Tracker model state and configuration
   logic [MIN_ELAPSED_W-1:0]  cfg_min_elapsed;
   logic [WRAP_THR_W-1:0]     cfg_wrap_thr;
   logic [SAMPLE_ANGLE_W-1:0] trk_angle;
   logic [TURN_COUNT_W-1:0]   trk_turns;
   logic [TIMESTAMP_W-1:0]    trk_time;
   logic [SAMPLE_ANGLE_W-1:0] trk_ref_angle;
   logic [TURN_COUNT_W-1:0]   trk_ref_turns;
   logic [TIMESTAMP_W-1:0]    trk_ref_time;
   logic [SPEED_W-1:0]        trk_speed;

   track_result_type pending_results [$];
   int               mismatch_count;
   int               stall_cycles;
   int               burst_left;
   int               ready_run;

   always #2 clock = ~clock;

   function automatic void clear_tracker();
      cfg_min_elapsed = MIN_ELAPSED_RST;
      cfg_wrap_thr    = WRAP_THR_RST;
      trk_angle       = '0;
      trk_turns       = '0;
      trk_time        = '0;
      trk_ref_angle   = '0;
      trk_ref_turns   = '0;
      trk_ref_time    = '0;
      trk_speed       = '0;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_MIN_ELAPSED: cfg_min_elapsed = data;
         CSR_WRAP_THR:    cfg_wrap_thr = data[WRAP_THR_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the tracker by one sample and return what the block should report
   function automatic track_result_type track_sample(logic [SAMPLE_ANGLE_W-1:0] angle,
                                                     logic err,
                                                     logic [TIMESTAMP_W-1:0] ts);
      track_result_type   res;
      logic signed [15:0] step;
      logic [14:0]        step_mag;
      logic [31:0]        elapsed;
      logic signed [33:0] turn_diff;
      logic signed [15:0] angle_diff;
      logic signed [49:0] delta;
      logic [79:0]        scaled;
      logic               updated;

      updated = 1'b0;
      if (!err) begin
         step     = $signed({2'b00, angle}) - $signed({2'b00, trk_angle});
         step_mag = (step < 0) ? 15'(-step) : 15'(step);
         trk_time = ts;
         // a large step is a wrap, counted against its direction
         if (step_mag > cfg_wrap_thr)
            trk_turns = (step > 0) ? trk_turns - 1 : trk_turns + 1;
         trk_angle = angle;

         elapsed = trk_time - trk_ref_time;
         if (elapsed[31]) begin
            trk_ref_angle = trk_angle;
            trk_ref_turns = trk_turns;
            trk_ref_time  = trk_time;
         end else if (elapsed >= cfg_min_elapsed && elapsed != 0) begin
            turn_diff  = $signed({{2{trk_turns[31]}}, trk_turns})
                       - $signed({{2{trk_ref_turns[31]}}, trk_ref_turns});
            angle_diff = $signed({2'b00, trk_angle}) - $signed({2'b00, trk_ref_angle});
            delta      = turn_diff;
            delta      = delta <<< ANGLE_W;
            delta      = delta + angle_diff;
            if (delta != 0) begin
               // exact floor of |delta| * 1e6 / elapsed, then saturate
               scaled = (delta < 0) ? 80'(-delta) : 80'(delta);
               scaled = (scaled * US_PER_SECOND) / {48'd0, elapsed};
               if (delta < 0)
                  trk_speed = (scaled > 80'h8000_0000) ? SPEED_NEG_SAT : -scaled[31:0];
               else
                  trk_speed = (scaled > 80'h7FFF_FFFF) ? SPEED_POS_SAT : scaled[31:0];
               trk_ref_angle = trk_angle;
               trk_ref_turns = trk_turns;
               trk_ref_time  = trk_time;
               updated = 1'b1;
            end
         end
      end

      res.turn_count    = trk_turns;
      res.shaft_angle   = trk_angle;
      res.total_angle   = {trk_turns, trk_angle};
      res.speed         = trk_speed;
      res.speed_updated = updated;
      return res;
   endfunction

   // Hold one request until taken, log its expected result, then maybe pause
   task automatic send_sample(input logic [SAMPLE_ANGLE_W-1:0] angle, input logic err,
                              input logic [TIMESTAMP_W-1:0] ts, input logic typed,
                              input track_result_type typed_result);
      track_result_type predicted;
      int               gap;

      req_bus.valid        <= 1'b1;
      req_bus.sample_angle <= angle;
      req_bus.sample_error <= err;
      req_bus.timestamp_us <= ts;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = track_sample(angle, err, ts);
      pending_results.push_back(typed ? typed_result : predicted);

      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 70);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
      end
   endtask

   // Drop valid and wait for every outstanding result
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Leaves valid high so back-to-back writes need no gap; caller drops it
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      apply_register(idx, data);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      track_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no request pending, expected none, got turn %0d",
                     $time, rsp_bus.turn_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("turn_count", want.turn_count, rsp_bus.turn_count);
            check_field("shaft_angle", want.shaft_angle, rsp_bus.shaft_angle);
            check_field("total_angle", want.total_angle, rsp_bus.total_angle);
            check_field("speed", want.speed, rsp_bus.speed);
            check_field("speed_updated", want.speed_updated, rsp_bus.speed_updated);
         end
      end
   end

   // Receiver: open and stalled stretches of random length
   always @(posedge clock) begin
      if (ready_run == 0) begin
         if (rsp_bus.ready) begin
            rsp_bus.ready <= 1'b0;
            ready_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                     : $urandom_range(0, 3);
         end else begin
            rsp_bus.ready <= 1'b1;
            ready_run <= ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 20);
         end
      end else begin
         ready_run <= ready_run - 1;
      end
   end

   // Watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
         $display("testbench: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row_type              row;
      track_result_type          want;
      logic [SAMPLE_ANGLE_W-1:0] gen_angle;
      logic [TIMESTAMP_W-1:0]    gen_time;
      logic [SAMPLE_ANGLE_W-1:0] angle;
      logic [TIMESTAMP_W-1:0]    ts;
      logic                      err;
      logic [MIN_ELAPSED_W-1:0]  min_set;
      logic [WRAP_THR_W-1:0]     thr_set;
      int                        max_step;
      int                        step;
      int                        roll;
      int                        kept;

      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.sample_angle = '0;
      req_bus.sample_error = 1'b0;
      req_bus.timestamp_us = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_MIN_ELAPSED;
      csr_bus.data         = '0;
      mismatch_count       = 0;
      stall_cycles         = 0;
      ready_run            = 0;
      burst_left           = $urandom_range(1, 24);
      clear_tracker();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_REG) begin
            if (i > 0 && directed_rows[i-1].kind == ROW_SAMPLE) drain();
            write_register(row.reg_index, row.reg_data);
            if (i + 1 == DIR_ROWS || directed_rows[i+1].kind != ROW_REG)
               csr_bus.valid <= 1'b0;
         end else begin
            want.turn_count    = row.want_turns;
            want.shaft_angle   = row.want_shaft;
            want.total_angle   = {row.want_turns, row.want_shaft};
            want.speed         = row.want_speed;
            want.speed_updated = row.want_updated;
            send_sample(row.angle, row.err, row.ts, row.typed, want);
         end
      end

      // Random motion profiles, each under its own configuration
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase % 4)
            0: begin
               min_set = MIN_ELAPSED_RST;
               thr_set = WRAP_THR_RST;
            end
            1: begin
               min_set = '0;
               thr_set = '1;
            end
            2: begin
               min_set = '1;
               thr_set = WRAP_THR_W'($urandom_range(8192, 16383));
            end
            default: begin
               min_set = MIN_ELAPSED_W'($urandom_range(0, 3000));
               thr_set = WRAP_THR_W'($urandom_range(0, 16383));
            end
         endcase
         write_register(CSR_MIN_ELAPSED, min_set);
         write_register(CSR_WRAP_THR, {2'($urandom_range(0, 3)), thr_set});
         if (phase == 3) write_register(CSR_UNUSED, 16'($urandom()));
         csr_bus.valid <= 1'b0;

         gen_angle = SAMPLE_ANGLE_W'($urandom());
         gen_time  = $urandom();
         max_step  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2500);
         kept      = 0;
         while (kept < SAMPLES_A_PHASE) begin
            roll = $urandom_range(0, 99);
            step = $urandom_range(0, 2 * max_step) - max_step;
            err  = 1'b0;
            if (roll < 5) begin
               // sensor error with random content
               err   = 1'b1;
               angle = SAMPLE_ANGLE_W'($urandom());
               ts    = $urandom();
            end else if (roll < 12) begin
               // jump anywhere; the profile continues from there
               gen_angle = SAMPLE_ANGLE_W'($urandom());
               gen_time  = $urandom();
               angle     = gen_angle;
               ts        = gen_time;
            end else begin
               if (roll < 16)
                  gen_time = gen_time - $urandom_range(1, 1 << 20);
               else if (roll >= 20)
                  gen_time = gen_time + $urandom_range(0, 2 * int'(cfg_min_elapsed) + 8);
               gen_angle = gen_angle + SAMPLE_ANGLE_W'(step);
               angle     = gen_angle;
               ts        = gen_time;
            end
            send_sample(angle, err, ts, 1'b0, '0);
            if (!err) kept++;
         end
      end

      drain();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rav_pkg.sv
rtl/core/rav_req_if.sv
rtl/core/rav_rsp_if.sv
rtl/core/rav_csr_if.sv
rtl/core/rotor_angle_velocity_tracker.sv
dv/testbench.sv
